FILE: rtl/u8pv_pkg.sv
// u8pv_pkg: shared types and constants for the utf8 path byte validator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package u8pv_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PEND_W    = 2;
    localparam int unsigned PARTIAL_W = 10;
    localparam int unsigned CP_W      = 16;

    localparam logic [BYTE_W-1:0]  LEAD_LOW  = 8'hE4;
    localparam logic [BYTE_W-1:0]  LEAD_HIGH = 8'hE9;
    localparam logic [BYTE_W-1:0]  CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0]  CONT_MARK = 8'h80;
    localparam logic [CP_W-1:0]    CP_LOW    = 16'h4E00;
    localparam logic [CP_W-1:0]    CP_HIGH   = 16'h9FA5;

    // continuation bytes still expected
    localparam logic [PEND_W-1:0]  PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0]  PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0]  PEND_TWO  = 2'd2;

    typedef struct packed {
        logic ascii_ok;
        logic is_ascii;
        logic is_lead;
        logic is_cont;
    } byte_class_t;

    typedef struct packed {
        logic [PEND_W-1:0]    pending;
        logic [PARTIAL_W-1:0] partial;
        logic                 reject;
    } path_state_t;

endpackage

FILE: rtl/u8pv_classify.sv
// u8pv_classify: sorts one path byte into ascii, lead and continuation classes
// depends on u8pv_pkg
`timescale 1ns / 1ps

module u8pv_classify
(
    input  logic [7:0]           path_byte,
    output u8pv_pkg::byte_class_t byte_class
);
    import u8pv_pkg::*;

    logic ascii_sym;
    logic ascii_space;
    logic ascii_digit;
    logic ascii_alpha;

    assign ascii_sym   = (path_byte == 8'h2E) || (path_byte == 8'h2F) ||
                         (path_byte == 8'h5F) || (path_byte == 8'h2D) ||
                         (path_byte == 8'h7E);
    assign ascii_space = (path_byte == 8'h20) ||
                         ((path_byte >= 8'h09) && (path_byte <= 8'h0D));
    assign ascii_digit = (path_byte >= 8'h30) && (path_byte <= 8'h39);
    assign ascii_alpha = ((path_byte >= 8'h41) && (path_byte <= 8'h5A)) ||
                         ((path_byte >= 8'h61) && (path_byte <= 8'h7A));

    always_comb
    begin
        byte_class.is_ascii = ~path_byte[7];
        byte_class.ascii_ok = ascii_sym | ascii_space | ascii_digit | ascii_alpha;
        byte_class.is_lead  = (path_byte >= LEAD_LOW) && (path_byte <= LEAD_HIGH);
        byte_class.is_cont  = ((path_byte & CONT_MASK) == CONT_MARK);
    end

endmodule

FILE: rtl/u8pv_step.sv
// u8pv_step: next path state and verdict for one classified byte
// depends on u8pv_pkg
`timescale 1ns / 1ps

module u8pv_step
(
    input  logic [7:0]            path_byte,
    input  u8pv_pkg::byte_class_t byte_class,
    input  u8pv_pkg::path_state_t cur_state,
    output u8pv_pkg::path_state_t next_state,
    output logic                  path_ok
);
    import u8pv_pkg::*;

    logic [CP_W-1:0] code_point;

    assign code_point = {cur_state.partial, path_byte[5:0]};

    always_comb
    begin
        next_state = cur_state;
        priority if (cur_state.reject)
        begin
            next_state.pending = PEND_NONE;
        end
        else if (cur_state.pending != PEND_NONE)
        begin
            if (!byte_class.is_cont)
            begin
                next_state.reject  = 1'b1;
                next_state.pending = PEND_NONE;
            end
            else if (cur_state.pending == PEND_TWO)
            begin
                next_state.partial = {cur_state.partial[3:0], path_byte[5:0]};
                next_state.pending = PEND_ONE;
            end
            else
            begin
                if ((code_point < CP_LOW) || (code_point > CP_HIGH))
                    next_state.reject = 1'b1;
                next_state.pending = PEND_NONE;
                next_state.partial = '0;
            end
        end
        else if (byte_class.is_ascii)
        begin
            if (!byte_class.ascii_ok)
                next_state.reject = 1'b1;
        end
        else if (byte_class.is_lead)
        begin
            next_state.partial = {6'd0, path_byte[3:0]};
            next_state.pending = PEND_TWO;
        end
        else
        begin
            next_state.reject = 1'b1;
        end
    end

    // a sequence cut short by the end of the path also fails
    assign path_ok = !next_state.reject && (next_state.pending == PEND_NONE);

endmodule

FILE: rtl/utf8_path_byte_validator.sv
// utf8_path_byte_validator: top level with input register, path state and verdict register
// depends on u8pv_pkg, u8pv_classify, u8pv_step
`timescale 1ns / 1ps

// Checks a path one byte per word and gives one verdict word (path_ok) for the byte
// marked is_last; other bytes give no output word. Allowed are ascii letters, digits,
// . / _ - ~ and whitespace, and three-byte sequences led by 0xE4..0xE9 that decode
// into U+4E00..U+9FA5. Any error is sticky until the end of the path, and the state
// clears after each verdict. One byte is taken every cycle unless in_stall is high: a byte
// sits in the input register, is checked by the classifier and step logic, and the
// verdict is registered in the output register. Bytes stall only while a last byte
// waits for a verdict that is still held by out_stall.
module utf8_path_byte_validator
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] path_byte,
    input  logic       is_last,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       path_ok,
    output logic       out_valid,
    input  logic       out_stall
);
    import u8pv_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    path_state_t state_reg;
    path_state_t state_next;
    logic        out_valid_reg;
    logic        ok_reg;
    logic        ok_next;
    byte_class_t byte_class;
    logic        advance;
    logic        in_take;

    // a non-last byte never needs the output register
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    u8pv_classify u_classify
    (
        .path_byte  (byte_reg),
        .byte_class (byte_class)
    );

    u8pv_step u_step
    (
        .path_byte  (byte_reg),
        .byte_class (byte_class),
        .cur_state  (state_reg),
        .next_state (state_next),
        .path_ok    (ok_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= path_byte;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            if (last_reg)
                state_reg <= '0;
            else
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            ok_reg <= ok_next;
    end

    assign out_valid = out_valid_reg;
    assign path_ok   = ok_reg;

`ifndef ASSERT_OFF
    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending != 2'd3)
        else $error("pending count out of range");

    a_reject_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.reject |-> (state_reg.pending == PEND_NONE))
        else $error("sticky error with continuation still pending");

    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (state_reg == '0) && out_valid_reg)
        else $error("state not cleared after verdict");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && last_reg && out_valid_reg && out_stall))
        else $error("input stalled without a held verdict");
`endif

endmodule

FILE: bench/utf8_path_byte_validator_test.sv
// utf8_path_byte_validator_test: self-checking bench for the utf8 path byte validator
// holds a verdict scoreboard with its own path checker; depends on u8pv_pkg and the rtl
`timescale 1ns / 1ps

module utf8_path_byte_validator_test;
    import u8pv_pkg::*;

    class verdict_scoreboard;
        path_state_t path_st = '0;
        logic        expected_verdicts[$];
        int          errors = 0;

        function logic path_char_allowed(logic [7:0] b);
            return b inside {8'h2E, 8'h2F, 8'h5F, 8'h2D, 8'h7E, 8'h20, [8'h09:8'h0D],
                             [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
        endfunction

        function void queue_verdict(logic v);
            expected_verdicts = {expected_verdicts, v};
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [CP_W-1:0] code;
            if (path_st.reject)
            begin
                path_st.pending = PEND_NONE;
            end
            else if (path_st.pending != PEND_NONE)
            begin
                if ((b & CONT_MASK) != CONT_MARK)
                begin
                    path_st.reject  = 1'b1;
                    path_st.pending = PEND_NONE;
                end
                else if (path_st.pending == PEND_TWO)
                begin
                    path_st.partial = {path_st.partial[3:0], b[5:0]};
                    path_st.pending = PEND_ONE;
                end
                else
                begin
                    code = {path_st.partial, b[5:0]};
                    if (code < CP_LOW || code > CP_HIGH)
                        path_st.reject = 1'b1;
                    path_st.pending = PEND_NONE;
                    path_st.partial = '0;
                end
            end
            else if (!b[7])
            begin
                if (!path_char_allowed(b))
                    path_st.reject = 1'b1;
            end
            else if (b >= LEAD_LOW && b <= LEAD_HIGH)
            begin
                path_st.partial = {6'd0, b[3:0]};
                path_st.pending = PEND_TWO;
            end
            else
            begin
                path_st.reject = 1'b1;
            end
            if (last)
            begin
                queue_verdict(!path_st.reject && path_st.pending == PEND_NONE);
                path_st = '0;
            end
        endfunction

        function void check_verdict(logic ok);
            logic want;
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: path_ok expected none, actual %0b", $time, ok);
                errors++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (ok !== want)
                begin
                    $display("%0t: path_ok expected %0b, actual %0b", $time, want, ok);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic [7:0] path_byte = 8'h00;
    logic       is_last = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       path_ok;
    logic       out_valid;
    logic       out_stall = 1'b0;

    verdict_scoreboard sb = new;
    logic [7:0]        path_bytes[$];
    logic              quiet = 1'b0;
    bit                tx_bursty = 1'b0;
    int                stall_left = 0;
    int                calm_left = 0;

    utf8_path_byte_validator dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .path_byte (path_byte),
        .is_last   (is_last),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .path_ok   (path_ok),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("utf8_path_byte_validator_test: errors");
        $finish;
    end

    // sample both channels at the edge, before any driven update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_verdict(path_ok);
            if (in_valid && !in_stall)
                sb.note_byte(path_byte, is_last);
        end
    end

    // receiver: random stall bursts, with calm stretches in between
    always @(posedge clk)
    begin
        if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (calm_left != 0)
        begin
            out_stall <= 1'b0;
            calm_left <= calm_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            // a calm stretch follows each burst
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
            calm_left  <= 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 15) == 0)
                calm_left <= $urandom_range(10, 50);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!quiet && tx_bursty && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        path_byte <= b;
        is_last   <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic run_path;
        foreach (path_bytes[i])
            send_byte(path_bytes[i], i == path_bytes.size() - 1);
    endtask

    // hold off the sender until every verdict has come back
    task automatic drain_verdicts;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_verdicts.size() != 0) @(posedge clk);
    endtask

    function automatic void append_byte(logic [7:0] b);
        path_bytes = {path_bytes, b};
    endfunction

    function automatic logic [7:0] pick_path_char();
        case ($urandom_range(0, 13))
            0, 1, 2:  return 8'(8'h61 + $urandom_range(0, 25));
            3, 4:     return 8'(8'h41 + $urandom_range(0, 25));
            5, 6:     return 8'(8'h30 + $urandom_range(0, 9));
            7:        return 8'h2E;
            8:        return 8'h2F;
            9:        return 8'h5F;
            10:       return 8'h2D;
            11:       return 8'h7E;
            12:       return 8'h20;
            default:  return 8'(8'h09 + $urandom_range(0, 4));
        endcase
    endfunction

    task automatic push_cjk;
        logic [CP_W-1:0] code;
        case ($urandom_range(0, 9))
            0:       code = CP_LOW;
            1:       code = CP_HIGH;
            default: code = CP_W'($urandom_range(CP_LOW, CP_HIGH));
        endcase
        append_byte({4'hE, code[15:12]});
        append_byte({2'b10, code[11:6]});
        append_byte({2'b10, code[5:0]});
    endtask

    task automatic build_path;
        int   tokens;
        int   kind;
        bit   noisy;
        logic [7:0] lead;
        path_bytes.delete();
        noisy  = $urandom_range(0, 3) == 0;
        tokens = $urandom_range(1, 10);
        repeat (tokens)
        begin
            kind = noisy ? $urandom_range(0, 9) : $urandom_range(0, 3);
            lead = 8'($urandom_range(LEAD_LOW, LEAD_HIGH));
            case (kind)
                0, 1: append_byte(pick_path_char());
                2, 3: push_cjk();
                4:    append_byte(8'($urandom_range(0, 255)));
                5:
                begin
                    // lead with random payload, sometimes outside the code point range
                    append_byte(lead);
                    append_byte({2'b10, 6'($urandom_range(0, 63))});
                    append_byte({2'b10, 6'($urandom_range(0, 63))});
                end
                6:
                begin
                    append_byte(lead);
                    if ($urandom_range(0, 1) == 0)
                        append_byte({2'b10, 6'($urandom_range(0, 63))});
                    append_byte({$urandom_range(0, 2) == 0 ? 2'b11 : 2'b0,
                                 6'($urandom_range(0, 63))});
                end
                7:
                begin
                    // sequence cut short, mid path or at the end
                    append_byte(lead);
                    if ($urandom_range(0, 1) == 0)
                        append_byte({2'b10, 6'($urandom_range(0, 63))});
                end
                8:       append_byte(8'($urandom_range(0, 127)));
                default: append_byte(8'($urandom_range(128, 255)));
            endcase
        end
    endtask

    initial
    begin
        int sent;
        int paths_done;
        sent = 0;
        paths_done = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_bursty = 1'b1;
        path_bytes = '{8'h61};               run_path();
        path_bytes = '{8'h00};               run_path();
        path_bytes = '{8'hFF};               run_path();
        path_bytes = '{8'hE4, 8'hB8, 8'h80}; run_path();
        path_bytes = '{8'hE9, 8'hBE, 8'hA5}; run_path();
        path_bytes = '{8'hE9, 8'hBE, 8'hA6}; run_path();
        path_bytes = '{8'hE4, 8'hB7, 8'hBF}; run_path();
        path_bytes = '{8'hE5, 8'h41};        run_path();
        path_bytes = '{8'hE5, 8'h80};        run_path();
        path_bytes = '{8'hE5};               run_path();
        path_bytes = '{8'h21, 8'h61};        run_path();
        path_bytes = '{8'hE3};               run_path();
        path_bytes = '{8'hEA, 8'h0D, 8'h09}; run_path();
        drain_verdicts();

        while (sent < 1950)
        begin
            build_path();
            if (sent > 1700)
                quiet <= 1'b1;
            tx_bursty = $urandom_range(0, 2) != 0;
            run_path();
            sent += path_bytes.size();
            paths_done++;
            if (paths_done == 40)
                drain_verdicts();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_verdicts.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("utf8_path_byte_validator_test: clean");
        else
            $display("utf8_path_byte_validator_test: errors");
        $finish;
    end
endmodule
